@@ hw/rtl/tli_pkg.sv @@
`default_nettype none

package tli_pkg;

    // Storage sizes
    localparam int PROGRAM_DEPTH = 4096;
    localparam int TAPE_DEPTH    = 32768;
    localparam int NEST_DEPTH    = 64;

    // Derived widths
    localparam int PA_W   = $clog2(PROGRAM_DEPTH);      // program address
    localparam int PL_W   = $clog2(PROGRAM_DEPTH + 1);  // program length / position
    localparam int TA_W   = $clog2(TAPE_DEPTH);         // tape address
    localparam int NA_W   = $clog2(NEST_DEPTH);         // bracket stack address
    localparam int ND_W   = $clog2(NEST_DEPTH + 1);     // bracket stack depth
    localparam int BYTE_W = 8;
    localparam int POS_W  = 13;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Program characters
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;  // [
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;  // ]
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;  // >
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;  // <
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;  // .
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;  // ,
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // +
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // -

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_STEP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_HALT    = 2'd1,
        STAT_BRACKET = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_LINK,
        ST_EXEC,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic link;
        logic exec;
        logic sweep;
        logic push;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        t_op  op;
        logic pop_needed;
        logic step_run;
        logic sweep_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/tli_ram.sv @@
`default_nettype none

module tli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tli_ctrl.sv @@
`default_nettype none

module tli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tli_pkg::t_stat i_stat,
    output tli_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);

    tli_pkg::t_state r_state;
    tli_pkg::t_state n_state;
    logic            r_clr_item;
    logic            n_clr_item;
    logic            w_accept;

    assign w_accept = (r_state == tli_pkg::ST_IDLE) && i_stat.in_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tli_pkg::ST_CLEAR: begin
                if (i_stat.sweep_done) begin
                    n_state = r_clr_item ? tli_pkg::ST_OUT : tli_pkg::ST_IDLE;
                end
            end
            tli_pkg::ST_IDLE: begin
                if (i_stat.in_valid) begin
                    unique case (i_stat.op)
                        tli_pkg::OP_LOAD: begin
                            n_state = i_stat.pop_needed ? tli_pkg::ST_POP : tli_pkg::ST_OUT;
                        end
                        tli_pkg::OP_STEP: begin
                            n_state = i_stat.step_run ? tli_pkg::ST_EXEC : tli_pkg::ST_OUT;
                        end
                        tli_pkg::OP_CLEAR: begin
                            n_state = tli_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = tli_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            tli_pkg::ST_POP:  n_state = tli_pkg::ST_LINK;
            tli_pkg::ST_LINK: n_state = tli_pkg::ST_OUT;
            tli_pkg::ST_EXEC: n_state = tli_pkg::ST_OUT;
            tli_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = tli_pkg::ST_IDLE;
                end
            end
            default: n_state = tli_pkg::ST_IDLE;
        endcase
    end

    // Remember whether the sweep answers an item or follows reset
    always_comb begin
        n_clr_item = r_clr_item;
        if (w_accept) begin
            n_clr_item = (i_stat.op == tli_pkg::OP_CLEAR);
        end
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tli_pkg::ST_CLEAR: o_cmd.sweep = 1'b1;
            tli_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_stat.in_valid;
            end
            tli_pkg::ST_POP:  o_cmd.pop  = 1'b1;
            tli_pkg::ST_LINK: o_cmd.link = 1'b1;
            tli_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            tli_pkg::ST_OUT:  o_cmd.push = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tli_pkg::ST_CLEAR;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tli_dp.sv @@
`default_nettype none

module tli_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tli_pkg::t_cmd                i_cmd,
    output tli_pkg::t_stat                    o_stat,
    input  wire logic                         i_in_valid,
    input  wire logic [tli_pkg::OP_W-1:0]     i_operation,
    input  wire logic [tli_pkg::BYTE_W-1:0]   i_program_byte,
    input  wire logic                         i_load_last,
    input  wire logic [tli_pkg::BYTE_W-1:0]   i_input_byte,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_output_valid,
    output logic      [tli_pkg::BYTE_W-1:0]   o_output_byte,
    output logic      [tli_pkg::STAT_W-1:0]   o_status,
    output logic      [tli_pkg::POS_W-1:0]    o_program_position
);

    // Control registers
    logic [tli_pkg::PL_W-1:0] r_len, n_len;
    logic [tli_pkg::PL_W-1:0] r_ip, n_ip;
    logic [tli_pkg::TA_W-1:0] r_cp, n_cp;
    logic [tli_pkg::ND_W-1:0] r_depth, n_depth;
    logic                     r_err, n_err;
    logic [tli_pkg::TA_W-1:0] r_clr_addr, n_clr_addr;
    logic                     r_m_valid, n_m_valid;

    // Payload registers
    logic [tli_pkg::PA_W-1:0]   r_link_pos;
    logic [tli_pkg::PA_W-1:0]   r_open;
    logic [tli_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_pend_valid;
    logic [tli_pkg::BYTE_W-1:0] r_pend_byte;
    tli_pkg::t_status           r_pend_status;
    logic                       r_out_flag;
    logic [tli_pkg::BYTE_W-1:0] r_out_byte;
    tli_pkg::t_status           r_out_status;
    logic [tli_pkg::POS_W-1:0]  r_out_pos;

    // Memory ports
    logic                       w_prog_we;
    logic [tli_pkg::BYTE_W-1:0] w_prog_rdata;
    logic                       w_match_we;
    logic [tli_pkg::PA_W-1:0]   w_match_waddr;
    logic [tli_pkg::PA_W-1:0]   w_match_wdata;
    logic [tli_pkg::PA_W-1:0]   w_match_rdata;
    logic                       w_stack_we;
    logic [tli_pkg::PA_W-1:0]   w_stack_rdata;
    logic                       w_tape_we;
    logic [tli_pkg::TA_W-1:0]   w_tape_waddr;
    logic [tli_pkg::BYTE_W-1:0] w_tape_wdata;
    logic [tli_pkg::BYTE_W-1:0] w_tape_rdata;

    // Decode of the incoming beat
    tli_pkg::t_op               w_op;
    logic                       w_acc_load;
    logic                       w_acc_step;
    logic                       w_full;
    logic                       w_is_open;
    logic                       w_is_close;
    logic                       w_nest_full;
    logic                       w_stack_empty;
    logic                       w_do_push;
    logic                       w_do_pop;
    logic [tli_pkg::ND_W-1:0]   w_depth_after;
    logic                       w_load_err;
    logic                       w_step_run;

    // Execute stage
    logic                       w_jump;
    logic [tli_pkg::PL_W-1:0]   w_ip_base;
    logic [tli_pkg::PL_W-1:0]   w_ip_next;
    logic                       w_cell_zero;
    logic                       w_tape_rdata_z;

    assign w_op          = tli_pkg::t_op'(i_operation);
    assign w_acc_load    = i_cmd.accept && (w_op == tli_pkg::OP_LOAD);
    assign w_acc_step    = i_cmd.accept && (w_op == tli_pkg::OP_STEP);
    assign w_full        = (r_len == tli_pkg::PL_W'(tli_pkg::PROGRAM_DEPTH));
    assign w_is_open     = (i_program_byte == tli_pkg::CH_OPEN);
    assign w_is_close    = (i_program_byte == tli_pkg::CH_CLOSE);
    assign w_nest_full   = (r_depth == tli_pkg::ND_W'(tli_pkg::NEST_DEPTH));
    assign w_stack_empty = (r_depth == '0);
    assign w_do_push     = !w_full && w_is_open && !w_nest_full;
    assign w_do_pop      = !w_full && w_is_close && !w_stack_empty;
    assign w_step_run    = !r_err && w_stack_empty && (r_ip < r_len);

    always_comb begin
        w_depth_after = r_depth;
        if (w_do_push) begin
            w_depth_after = r_depth + 1'b1;
        end else if (w_do_pop) begin
            w_depth_after = r_depth - 1'b1;
        end
    end

    assign w_load_err = r_err
                     || (!w_full && w_is_open && w_nest_full)
                     || (!w_full && w_is_close && w_stack_empty)
                     || (i_load_last && (w_depth_after != '0));

    // Step decode on registered memory data
    assign w_cell_zero = (w_tape_rdata_z == 1'b1);
    assign w_tape_rdata_z = (w_tape_rdata == '0);

    always_comb begin
        w_jump = 1'b0;
        if (w_prog_rdata == tli_pkg::CH_OPEN) begin
            w_jump = w_cell_zero;
        end else if (w_prog_rdata == tli_pkg::CH_CLOSE) begin
            w_jump = !w_cell_zero;
        end
    end

    assign w_ip_base = w_jump ? tli_pkg::PL_W'(w_match_rdata) : r_ip;
    assign w_ip_next = w_ip_base + 1'b1;

    // Status toward the controller
    always_comb begin
        o_stat            = '0;
        o_stat.in_valid   = i_in_valid;
        o_stat.op         = w_op;
        o_stat.pop_needed = w_do_pop;
        o_stat.step_run   = w_step_run;
        o_stat.sweep_done = (r_clr_addr == tli_pkg::TA_W'(tli_pkg::TAPE_DEPTH - 1));
        o_stat.out_free   = !r_m_valid || i_out_ready;
    end

    // Next values of the control registers
    always_comb begin
        n_len      = r_len;
        n_ip       = r_ip;
        n_cp       = r_cp;
        n_depth    = r_depth;
        n_err      = r_err;
        n_clr_addr = r_clr_addr;
        n_m_valid  = r_m_valid;

        if (w_acc_load) begin
            n_depth = w_depth_after;
            n_err   = w_load_err;
            if (!w_full) begin
                n_len = r_len + 1'b1;
            end
        end

        if (i_cmd.accept && (w_op == tli_pkg::OP_CLEAR)) begin
            n_len      = '0;
            n_ip       = '0;
            n_cp       = '0;
            n_depth    = '0;
            n_err      = 1'b0;
            n_clr_addr = '0;
        end

        if (i_cmd.exec) begin
            n_ip = w_ip_next;
            if (w_prog_rdata == tli_pkg::CH_RIGHT) begin
                n_cp = (r_cp == tli_pkg::TA_W'(tli_pkg::TAPE_DEPTH - 1)) ? '0 : r_cp + 1'b1;
            end else if (w_prog_rdata == tli_pkg::CH_LEFT) begin
                n_cp = (r_cp == '0) ? tli_pkg::TA_W'(tli_pkg::TAPE_DEPTH - 1) : r_cp - 1'b1;
            end
        end

        // Sweep the tape, wrapping back to zero at the end
        if (i_cmd.sweep) begin
            n_clr_addr = (r_clr_addr == tli_pkg::TA_W'(tli_pkg::TAPE_DEPTH - 1))
                       ? '0 : r_clr_addr + 1'b1;
        end

        // Output register: fill on push, drain on ready
        if (i_cmd.push) begin
            n_m_valid = 1'b1;
        end else if (i_out_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ip       <= '0;
            r_cp       <= '0;
            r_depth    <= '0;
            r_err      <= 1'b0;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_ip       <= n_ip;
            r_cp       <= n_cp;
            r_depth    <= n_depth;
            r_err      <= n_err;
            r_clr_addr <= n_clr_addr;
            r_m_valid  <= n_m_valid;
        end
    end

    // Pending result and link bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_valid <= 1'b0;
            r_pend_byte  <= '0;
            r_link_pos   <= tli_pkg::PA_W'(r_len);
            r_in_byte    <= i_input_byte;
            case (w_op)
                tli_pkg::OP_LOAD: begin
                    if (w_full) begin
                        r_pend_status <= tli_pkg::STAT_FULL;
                    end else begin
                        r_pend_status <= w_load_err ? tli_pkg::STAT_BRACKET : tli_pkg::STAT_OK;
                    end
                end
                tli_pkg::OP_STEP: begin
                    if (r_err || !w_stack_empty) begin
                        r_pend_status <= tli_pkg::STAT_BRACKET;
                    end else begin
                        r_pend_status <= tli_pkg::STAT_HALT;
                    end
                end
                tli_pkg::OP_CLEAR: r_pend_status <= tli_pkg::STAT_OK;
                default: r_pend_status <= r_err ? tli_pkg::STAT_BRACKET : tli_pkg::STAT_OK;
            endcase
        end
        if (i_cmd.pop) begin
            r_open <= w_stack_rdata;
        end
        if (i_cmd.exec) begin
            r_pend_status <= (w_ip_next >= r_len) ? tli_pkg::STAT_HALT : tli_pkg::STAT_OK;
            if (w_prog_rdata == tli_pkg::CH_DOT) begin
                r_pend_valid <= 1'b1;
                r_pend_byte  <= w_tape_rdata;
            end
        end
        if (i_cmd.push) begin
            r_out_flag   <= r_pend_valid;
            r_out_byte   <= r_pend_byte;
            r_out_status <= r_pend_status;
            r_out_pos    <= tli_pkg::POS_W'(r_ip);
        end
    end

    // Program store
    assign w_prog_we = w_acc_load && !w_full;

    tli_ram #(
        .WIDTH (tli_pkg::BYTE_W),
        .DEPTH (tli_pkg::PROGRAM_DEPTH)
    ) u_prog_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_prog_we),
        .i_wr_addr (tli_pkg::PA_W'(r_len)),
        .i_wr_data (i_program_byte),
        .i_rd_en   (w_acc_step),
        .i_rd_addr (tli_pkg::PA_W'(r_ip)),
        .o_rd_data (w_prog_rdata)
    );

    // Match table: closing entry on pop, opening entry on link
    assign w_match_we    = i_cmd.pop || i_cmd.link;
    assign w_match_waddr = i_cmd.pop ? r_link_pos : r_open;
    assign w_match_wdata = i_cmd.pop ? w_stack_rdata : r_link_pos;

    tli_ram #(
        .WIDTH (tli_pkg::PA_W),
        .DEPTH (tli_pkg::PROGRAM_DEPTH)
    ) u_match_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_match_we),
        .i_wr_addr (w_match_waddr),
        .i_wr_data (w_match_wdata),
        .i_rd_en   (w_acc_step),
        .i_rd_addr (tli_pkg::PA_W'(r_ip)),
        .o_rd_data (w_match_rdata)
    );

    // Bracket stack
    assign w_stack_we = w_acc_load && w_do_push;

    tli_ram #(
        .WIDTH (tli_pkg::PA_W),
        .DEPTH (tli_pkg::NEST_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_stack_we),
        .i_wr_addr (tli_pkg::NA_W'(r_depth)),
        .i_wr_data (tli_pkg::PA_W'(r_len)),
        .i_rd_en   (w_acc_load),
        .i_rd_addr (tli_pkg::NA_W'(r_depth - 1'b1)),
        .o_rd_data (w_stack_rdata)
    );

    // Tape: sweep writes zero, execute writes the modified cell
    always_comb begin
        w_tape_we    = 1'b0;
        w_tape_waddr = r_cp;
        w_tape_wdata = r_in_byte;
        if (i_cmd.sweep) begin
            w_tape_we    = 1'b1;
            w_tape_waddr = r_clr_addr;
            w_tape_wdata = '0;
        end else if (i_cmd.exec) begin
            if (w_prog_rdata == tli_pkg::CH_PLUS) begin
                w_tape_we    = 1'b1;
                w_tape_wdata = w_tape_rdata + 1'b1;
            end else if (w_prog_rdata == tli_pkg::CH_MINUS) begin
                w_tape_we    = 1'b1;
                w_tape_wdata = w_tape_rdata - 1'b1;
            end else if (w_prog_rdata == tli_pkg::CH_COMMA) begin
                w_tape_we    = 1'b1;
                w_tape_wdata = r_in_byte;
            end
        end
    end

    tli_ram #(
        .WIDTH (tli_pkg::BYTE_W),
        .DEPTH (tli_pkg::TAPE_DEPTH)
    ) u_tape_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_tape_we),
        .i_wr_addr (w_tape_waddr),
        .i_wr_data (w_tape_wdata),
        .i_rd_en   (w_acc_step),
        .i_rd_addr (r_cp),
        .o_rd_data (w_tape_rdata)
    );

    assign o_out_valid        = r_m_valid;
    assign o_output_valid     = r_out_flag;
    assign o_output_byte      = r_out_byte;
    assign o_status           = r_out_status;
    assign o_program_position = r_out_pos;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= tli_pkg::ND_W'(tli_pkg::NEST_DEPTH))
        else $error("bracket stack deeper than its storage");

    a_ip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ip <= r_len)
        else $error("instruction position beyond program end");

    a_out_flag_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_out_flag) |->
            (r_out_status == tli_pkg::STAT_OK || r_out_status == tli_pkg::STAT_HALT))
        else $error("output byte flagged on a non-step result");

    a_sweep_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && $past(i_cmd.sweep) && $past(i_rst_n)) |->
            (r_clr_addr != $past(r_clr_addr)))
        else $error("tape sweep stalled");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tape_language_interpreter_core.sv @@
// Channel   Dir  tdata                                   tuser            tlast
// s_axis    in   [7:0] program_byte, [15:8] input_byte   [1:0] operation  load_last
// m_axis    out  [7:0] output_byte, [9:8] status,        [0] output_valid -
//                [22:10] program_position, [23] zero
//
// Cycles from accept to result: load 2, load of a ']' that closes a bracket 4,
// step that runs an instruction 3, blocked or halted step and unknown operation 2
// (read program, match entry and tape cell, then one read-modify-write of the cell).
// Clear and reset run a sweep over the tape, one cell a cycle: TAPE_DEPTH cycles
// during which no beat is accepted; a clear returns its result after the sweep.
// One item is in flight at a time; a finished result waits in the output register
// while the next beat is taken, and a further result waits until it drains.
`default_nettype none

module tape_language_interpreter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // program_byte, input_byte
    input  wire logic [1:0]  s_axis_tuser,   // operation
    input  wire logic        s_axis_tlast,   // load_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // output_byte, status, program_position
    output logic      [0:0]  m_axis_tuser    // output_valid
);

    tli_pkg::t_cmd                w_cmd;
    tli_pkg::t_stat               w_stat;
    logic                         w_output_valid;
    logic [tli_pkg::BYTE_W-1:0]   w_output_byte;
    logic [tli_pkg::STAT_W-1:0]   w_status;
    logic [tli_pkg::POS_W-1:0]    w_position;

    tli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    tli_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_in_valid         (s_axis_tvalid),
        .i_operation        (s_axis_tuser),
        .i_program_byte     (s_axis_tdata[7:0]),
        .i_load_last        (s_axis_tlast),
        .i_input_byte       (s_axis_tdata[15:8]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_output_valid     (w_output_valid),
        .o_output_byte      (w_output_byte),
        .o_status           (w_status),
        .o_program_position (w_position)
    );

    // Pack the result beat
    assign m_axis_tdata = {1'b0, w_position, w_status, w_output_byte};
    assign m_axis_tuser = w_output_valid;

endmodule

`default_nettype wire
